[src/univariate_global_min_search_defines.svh]
// ----------------------------------------------------------------------------
// univariate global min search assertion macros
// shared assertion helpers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef UNIVARIATE_GLOBAL_MIN_SEARCH_DEFINES_SVH
`define UNIVARIATE_GLOBAL_MIN_SEARCH_DEFINES_SVH

`ifndef SYNTHESIS
`define UGMS_ASSERT_IMP(lbl, a, b) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) |-> (b)) \
        else $error("assertion failed");
`define UGMS_ASSERT_NXT(lbl, a, b) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define UGMS_ASSERT_IMP(lbl, a, b)
`define UGMS_ASSERT_NXT(lbl, a, b)
`endif

`endif

[src/ugms_pkg.sv]
// ----------------------------------------------------------------------------
// ugms_pkg
// types, constants and helpers of the global minimum search block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ugms_pkg;

    localparam int DEF_MAX_POINTS = 256;

    localparam logic signed [31:0] RST_LOWER   = 32'sd0;
    localparam logic signed [31:0] RST_UPPER   = 32'sd65536;
    localparam logic [30:0]        RST_TOL     = 31'd66;
    localparam logic [30:0]        RST_RESERVE = 31'd32768;

    localparam logic [1:0] REG_LOWER   = 2'd0;
    localparam logic [1:0] REG_UPPER   = 2'd1;
    localparam logic [1:0] REG_TOL     = 2'd2;
    localparam logic [1:0] REG_RESERVE = 2'd3;

    localparam logic [1:0] ST_RUNNING   = 2'd0;
    localparam logic [1:0] ST_CONVERGED = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_ZERO_DIV  = 2'd3;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WANT_B,
        PH_RUN,
        PH_DONE
    } phase_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_INS_LAST,
        S_CHK0,
        S_CHK1,
        S_CHK2,
        S_ADV,
        S_PK_RD,
        S_PK_CAP,
        S_PK_MUL,
        S_PK_DIV,
        S_PK_WAIT,
        S_PR0,
        S_PR1,
        S_PR2,
        S_PR3,
        S_PR_WAIT,
        S_PR_MUL,
        S_PR_ADD,
        S_EMIT
    } seq_state_t;

    typedef struct packed {
        logic               restart;
        logic signed [31:0] value;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] next_point;
        logic               finished;
        logic [8:0]         point_count;
        logic [1:0]         status;
    } out_word_t;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    // r + z - zmin clamped at zero
    function automatic logic [32:0] excess(input logic [30:0] r,
                                           input logic signed [31:0] z,
                                           input logic signed [31:0] zmin);
        logic signed [33:0] e;
        e = $signed({3'b000, r}) + 34'(z) - 34'(zmin);
        return e[33] ? 33'd0 : e[32:0];
    endfunction

    function automatic logic [31:0] sat32(input logic [32:0] e);
        return e[32] ? 32'hFFFF_FFFF : e[31:0];
    endfunction

endpackage

[src/ugms_ram.sv]
// ----------------------------------------------------------------------------
// ugms_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ugms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/ugms_div.sv]
// ----------------------------------------------------------------------------
// ugms_div
// restoring divider, 64 by 32 bits unsigned, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ugms_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  ugms_pkg::div_req_t req,
    output logic              done,
    output logic [63:0]       quotient
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [63:0] q_reg, q_next;
    logic [31:0] div_reg, div_next;
    logic [32:0] trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        div_next  = div_reg;
        trial     = {rem_reg, q_reg[63]};
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = 7'd64;
            rem_next  = 32'd0;
            q_next    = req.dividend;
            div_next  = req.divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, div_reg}) begin
                rem_next = 32'(trial - {1'b0, div_reg});
                q_next   = {q_reg[62:0], 1'b1};
            end else begin
                rem_next = trial[31:0];
                q_next   = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        q_reg   <= q_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

[src/univariate_global_min_search.sv]
// a restart word stores the lower bound and its value, and its result asks for the upper bound
// word for b: answered directly when the interval already meets the tolerance, else one interval search and a proposal
// search word: shifts the k larger entries up to insert its point, then checks convergence and scans its n points
// the shared divider is used once per interval of positive width and at most once for the proposal
// one word in work at a time, the next is taken once the result is registered at the output
// reset: control registers reset synchronously, the point and value rams are not cleared
// ----------------------------------------------------------------------------
// univariate_global_min_search
// one-dimensional global minimum search, sorted sample store, shared mul/div
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "univariate_global_min_search_defines.svh"

module univariate_global_min_search #(
    parameter int MAX_POINTS = ugms_pkg::DEF_MAX_POINTS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ugms_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ugms_pkg::out_word_t m_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] MAXC = CW'(MAX_POINTS);

    // configuration
    logic signed [31:0] lower_reg, upper_reg;
    logic [30:0]        tol_reg, resv_reg;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lower_reg <= ugms_pkg::RST_LOWER;
            upper_reg <= ugms_pkg::RST_UPPER;
            tol_reg   <= ugms_pkg::RST_TOL;
            resv_reg  <= ugms_pkg::RST_RESERVE;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                ugms_pkg::REG_LOWER:   lower_reg <= pwdata;
                ugms_pkg::REG_UPPER:   upper_reg <= pwdata;
                ugms_pkg::REG_TOL:     tol_reg   <= pwdata[30:0];
                ugms_pkg::REG_RESERVE: resv_reg  <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            ugms_pkg::REG_LOWER:   prdata = lower_reg;
            ugms_pkg::REG_UPPER:   prdata = upper_reg;
            ugms_pkg::REG_TOL:     prdata = {1'b0, tol_reg};
            ugms_pkg::REG_RESERVE: prdata = {1'b0, resv_reg};
            default:               prdata = 32'd0;
        endcase
    end

    // sequencer state
    ugms_pkg::seq_state_t state_reg, state_next;
    ugms_pkg::phase_t     phase_reg, phase_next;
    logic [CW-1:0]        count_reg, count_next;
    logic signed [31:0]   zmin_reg, zmin_next;
    logic signed [31:0]   pend_reg, pend_next;
    logic [AW-1:0]        chosen_reg, chosen_next;
    logic [1:0]           stat_reg, stat_next;
    logic signed [31:0]   x0_reg, x0_next;
    logic signed [31:0]   zin_reg, zin_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic [AW-1:0]        best_reg, best_next;
    logic                 found_reg, found_next;
    logic [63:0]          bq_reg, bq_next;
    logic signed [31:0]   ppt_reg, ppt_next;
    logic signed [31:0]   pval_reg, pval_next;
    logic [32:0]          u_reg, u_next;
    logic [32:0]          v_reg, v_next;
    logic signed [32:0]   w_reg, w_next;
    logic [64:0]          prod_reg, prod_next;
    logic                 mv_reg, mv_next;
    ugms_pkg::out_word_t  md_reg, md_next;

    // ram ports
    logic               we;
    logic [AW-1:0]      waddr, raddr;
    logic signed [31:0] wpt, wval, rpt, rval;

    ugms_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_pt_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wpt), .raddr(raddr), .rdata(rpt)
    );

    ugms_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_val_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wval), .raddr(raddr), .rdata(rval)
    );

    // shared divider and multiplier
    ugms_pkg::div_req_t div_req;
    logic               div_done;
    logic [63:0]        div_q;

    ugms_div u_div (
        .aclk(aclk), .aresetn(aresetn), .req(div_req), .done(div_done), .quotient(div_q)
    );

    logic [31:0] mul_a;
    logic [32:0] mul_b;
    logic [64:0] mul_p;
    assign mul_p = 65'(mul_a) * 65'(mul_b);

    logic               accept;
    logic               div_wait;
    logic signed [32:0] gap;
    logic [32:0]        eu, ev;
    logic [33:0]        sum_uv;
    logic [32:0]        us, vs;
    logic [33:0]        sum_s;
    logic [CW-1:0]      idx_inc;
    logic [31:0]        cnt32;

    assign s_ready  = (state_reg == ugms_pkg::S_IDLE);
    assign accept   = s_valid && s_ready;
    assign cnt32    = 32'(count_reg);
    assign div_wait = (state_reg == ugms_pkg::S_PK_WAIT) || (state_reg == ugms_pkg::S_PR_WAIT);

    always_comb begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        count_next  = count_reg;
        zmin_next   = zmin_reg;
        pend_next   = pend_reg;
        chosen_next = chosen_reg;
        stat_next   = stat_reg;
        x0_next     = x0_reg;
        zin_next    = zin_reg;
        idx_next    = idx_reg;
        best_next   = best_reg;
        found_next  = found_reg;
        bq_next     = bq_reg;
        ppt_next    = ppt_reg;
        pval_next   = pval_reg;
        u_next      = u_reg;
        v_next      = v_reg;
        w_next      = w_reg;
        prod_next   = prod_reg;
        mv_next     = mv_reg;
        md_next     = md_reg;
        we          = 1'b0;
        waddr       = '0;
        wpt         = pend_reg;
        wval        = zin_reg;
        raddr       = idx_reg;
        div_req     = '0;
        mul_a       = u_reg[31:0];
        mul_b       = {1'b0, v_reg[31:0]};
        gap         = 33'(rpt) - 33'(ppt_reg);
        eu          = ugms_pkg::excess(resv_reg, pval_reg, zmin_reg);
        ev          = ugms_pkg::excess(resv_reg, rval, zmin_reg);
        sum_uv      = 34'(u_reg) + 34'(v_reg);
        us          = u_reg >> 2;
        vs          = v_reg >> 2;
        sum_s       = 34'(us) + 34'(vs);
        idx_inc     = CW'(idx_reg) + CW'(1);

        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end

        case (state_reg)
            ugms_pkg::S_IDLE: begin
                if (accept) begin
                    state_next = ugms_pkg::S_EMIT;
                    if (s_data.restart) begin
                        we          = 1'b1;
                        waddr       = '0;
                        wpt         = lower_reg;
                        wval        = s_data.value;
                        x0_next     = lower_reg;
                        count_next  = CW'(1);
                        zmin_next   = s_data.value;
                        pend_next   = upper_reg;
                        chosen_next = AW'(1);
                        stat_next   = ugms_pkg::ST_RUNNING;
                        phase_next  = ugms_pkg::PH_WANT_B;
                    end else if (phase_reg == ugms_pkg::PH_WANT_B) begin
                        we         = 1'b1;
                        waddr      = AW'(1);
                        wpt        = upper_reg;
                        wval       = s_data.value;
                        count_next = CW'(2);
                        if (s_data.value < zmin_reg) begin
                            zmin_next = s_data.value;
                        end
                        pend_next = upper_reg;
                        if ((33'(upper_reg) - 33'(x0_reg)) <= $signed({2'b00, tol_reg})) begin
                            phase_next = ugms_pkg::PH_DONE;
                            stat_next  = ugms_pkg::ST_CONVERGED;
                        end else begin
                            phase_next = ugms_pkg::PH_RUN;
                            state_next = ugms_pkg::S_ADV;
                        end
                    end else if (phase_reg == ugms_pkg::PH_RUN) begin
                        zin_next = s_data.value;
                        if (s_data.value < zmin_reg) begin
                            zmin_next = s_data.value;
                        end
                        idx_next   = AW'(count_reg - CW'(1));
                        state_next = ugms_pkg::S_INS_RD;
                    end
                end
            end
            ugms_pkg::S_INS_RD: begin
                raddr      = idx_reg;
                state_next = ugms_pkg::S_INS_CMP;
            end
            ugms_pkg::S_INS_CMP: begin
                we    = 1'b1;
                waddr = idx_inc[AW-1:0];
                if (pend_reg < rpt) begin
                    wpt  = rpt;
                    wval = rval;
                    if (idx_reg == '0) begin
                        state_next = ugms_pkg::S_INS_LAST;
                    end else begin
                        idx_next   = idx_reg - AW'(1);
                        state_next = ugms_pkg::S_INS_RD;
                    end
                end else begin
                    count_next = count_reg + CW'(1);
                    state_next = ugms_pkg::S_CHK0;
                end
            end
            ugms_pkg::S_INS_LAST: begin
                we         = 1'b1;
                waddr      = '0;
                count_next = count_reg + CW'(1);
                state_next = ugms_pkg::S_CHK0;
            end
            ugms_pkg::S_CHK0: begin
                raddr      = chosen_reg - AW'(1);
                state_next = ugms_pkg::S_CHK1;
            end
            ugms_pkg::S_CHK1: begin
                raddr      = chosen_reg;
                ppt_next   = rpt;
                state_next = ugms_pkg::S_CHK2;
            end
            ugms_pkg::S_CHK2: begin
                if (CW'(chosen_reg) < count_reg && gap <= $signed({2'b00, tol_reg})) begin
                    phase_next = ugms_pkg::PH_DONE;
                    stat_next  = ugms_pkg::ST_CONVERGED;
                    state_next = ugms_pkg::S_EMIT;
                end else begin
                    state_next = ugms_pkg::S_ADV;
                end
            end
            ugms_pkg::S_ADV: begin
                if (count_reg >= MAXC) begin
                    phase_next = ugms_pkg::PH_DONE;
                    stat_next  = ugms_pkg::ST_FULL;
                    state_next = ugms_pkg::S_EMIT;
                end else begin
                    idx_next   = '0;
                    found_next = 1'b0;
                    best_next  = AW'(1);
                    state_next = ugms_pkg::S_PK_RD;
                end
            end
            ugms_pkg::S_PK_RD: begin
                raddr      = idx_reg;
                state_next = ugms_pkg::S_PK_CAP;
            end
            ugms_pkg::S_PK_CAP: begin
                ppt_next  = rpt;
                pval_next = rval;
                if (idx_reg == '0) begin
                    idx_next   = AW'(1);
                    state_next = ugms_pkg::S_PK_RD;
                end else begin
                    u_next = {1'b0, ugms_pkg::sat32(eu)};
                    v_next = {1'b0, ugms_pkg::sat32(ev)};
                    w_next = gap;
                    if (gap <= 0) begin
                        if (idx_inc < count_reg) begin
                            idx_next   = idx_inc[AW-1:0];
                            state_next = ugms_pkg::S_PK_RD;
                        end else begin
                            state_next = ugms_pkg::S_PR0;
                        end
                    end else begin
                        state_next = ugms_pkg::S_PK_MUL;
                    end
                end
            end
            ugms_pkg::S_PK_MUL: begin
                prod_next  = mul_p;
                state_next = ugms_pkg::S_PK_DIV;
            end
            ugms_pkg::S_PK_DIV: begin
                div_req.start    = 1'b1;
                div_req.dividend = prod_reg[63:0];
                div_req.divisor  = w_reg[31:0];
                state_next       = ugms_pkg::S_PK_WAIT;
            end
            ugms_pkg::S_PK_WAIT: begin
                if (div_done) begin
                    if (!found_reg || div_q < bq_reg) begin
                        found_next = 1'b1;
                        bq_next    = div_q;
                        best_next  = idx_reg;
                    end
                    if (idx_inc < count_reg) begin
                        idx_next   = idx_inc[AW-1:0];
                        state_next = ugms_pkg::S_PK_RD;
                    end else begin
                        state_next = ugms_pkg::S_PR0;
                    end
                end
            end
            ugms_pkg::S_PR0: begin
                chosen_next = best_reg;
                raddr       = best_reg - AW'(1);
                state_next  = ugms_pkg::S_PR1;
            end
            ugms_pkg::S_PR1: begin
                raddr      = chosen_reg;
                ppt_next   = rpt;
                pval_next  = rval;
                state_next = ugms_pkg::S_PR2;
            end
            ugms_pkg::S_PR2: begin
                u_next     = eu;
                v_next     = ev;
                w_next     = gap;
                state_next = ugms_pkg::S_PR3;
            end
            ugms_pkg::S_PR3: begin
                if (sum_uv == '0) begin
                    phase_next = ugms_pkg::PH_DONE;
                    stat_next  = ugms_pkg::ST_ZERO_DIV;
                    state_next = ugms_pkg::S_EMIT;
                end else if (w_reg <= 0) begin
                    pend_next  = ppt_reg;
                    state_next = ugms_pkg::S_EMIT;
                end else begin
                    div_req.start = 1'b1;
                    if (sum_uv[33:32] != 2'b00) begin
                        div_req.dividend = {us[31:0], 32'd0};
                        div_req.divisor  = sum_s[31:0];
                    end else begin
                        div_req.dividend = {u_reg[31:0], 32'd0};
                        div_req.divisor  = sum_uv[31:0];
                    end
                    state_next = ugms_pkg::S_PR_WAIT;
                end
            end
            ugms_pkg::S_PR_WAIT: begin
                if (div_done) begin
                    state_next = ugms_pkg::S_PR_MUL;
                end
            end
            ugms_pkg::S_PR_MUL: begin
                mul_a      = w_reg[31:0];
                mul_b      = div_q[32:0];
                prod_next  = mul_p;
                state_next = ugms_pkg::S_PR_ADD;
            end
            ugms_pkg::S_PR_ADD: begin
                pend_next  = 32'(ppt_reg + $signed(prod_reg[63:32]));
                state_next = ugms_pkg::S_EMIT;
            end
            ugms_pkg::S_EMIT: begin
                if (!mv_reg || m_ready) begin
                    mv_next = 1'b1;
                    if (phase_reg == ugms_pkg::PH_IDLE) begin
                        md_next.next_point  = lower_reg;
                        md_next.finished    = 1'b0;
                        md_next.point_count = 9'd0;
                        md_next.status      = ugms_pkg::ST_RUNNING;
                    end else begin
                        md_next.next_point  = pend_reg;
                        md_next.finished    = (phase_reg == ugms_pkg::PH_DONE);
                        md_next.point_count = cnt32[8:0];
                        md_next.status      = (phase_reg == ugms_pkg::PH_DONE) ?
                                              stat_reg : ugms_pkg::ST_RUNNING;
                    end
                    state_next = ugms_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = ugms_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ugms_pkg::S_IDLE;
            phase_reg  <= ugms_pkg::PH_IDLE;
            count_reg  <= '0;
            zmin_reg   <= '0;
            pend_reg   <= '0;
            chosen_reg <= AW'(1);
            stat_reg   <= ugms_pkg::ST_RUNNING;
            found_reg  <= 1'b0;
            mv_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            zmin_reg   <= zmin_next;
            pend_reg   <= pend_next;
            chosen_reg <= chosen_next;
            stat_reg   <= stat_next;
            found_reg  <= found_next;
            mv_reg     <= mv_next;
        end
        x0_reg   <= x0_next;
        zin_reg  <= zin_next;
        idx_reg  <= idx_next;
        best_reg <= best_next;
        bq_reg   <= bq_next;
        ppt_reg  <= ppt_next;
        pval_reg <= pval_next;
        u_reg    <= u_next;
        v_reg    <= v_next;
        w_reg    <= w_next;
        prod_reg <= prod_next;
        md_reg   <= md_next;
    end

    assign m_valid = mv_reg;
    assign m_data  = md_reg;

    `UGMS_ASSERT_NXT(a_busy_after_accept, accept, !s_ready)
    `UGMS_ASSERT_IMP(a_div_done_waited, div_done, div_wait)
    `UGMS_ASSERT_IMP(a_run_not_full, (state_reg == ugms_pkg::S_IDLE && phase_reg == ugms_pkg::PH_RUN), count_reg < MAXC)
    `UGMS_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= MAXC)

endmodule
